// File: rtl/dpb_pkg.sv
// Package for the disparity back-projection block: register map, field widths
// and the configuration struct. No dependencies.
`default_nettype none

package dpb_pkg;

  localparam int CENTER_FRAC_BITS = 4;
  localparam int FOCAL_FRAC_BITS  = 24;
  localparam int SCALE_BITS       = CENTER_FRAC_BITS + FOCAL_FRAC_BITS;

  localparam int COEF_W   = 32;
  localparam int LIMIT_W  = 20;
  localparam int RECIP_W  = 24;
  localparam int CENTER_W = 16;
  localparam int STRIDE_W = 3;
  localparam int DISP_W   = 16;
  localparam int Z_W      = 20;
  localparam int POINT_W  = 32;

  localparam int DIV_BITS_PER_STAGE = 4;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_COEF   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X_RCP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y_RCP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_SHIFT = 3'd6;

  localparam logic [LIMIT_W-1:0] DEPTH_LIMIT_RESET = 20'hFFFFF;

  typedef struct packed {
    logic [COEF_W-1:0]   depth_coefficient;
    logic [LIMIT_W-1:0]  depth_limit;
    logic [RECIP_W-1:0]  focal_x_reciprocal;
    logic [RECIP_W-1:0]  focal_y_reciprocal;
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
    logic [STRIDE_W-1:0] stride_shift;
  } cfg_t;

endpackage

`default_nettype wire

// File: rtl/dpb_cfg.sv
// Configuration register file behind an APB-style port.
// Depends on dpb_pkg for the register map and cfg_t.
`default_nettype none

module dpb_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [dpb_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [dpb_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [dpb_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                pready,
  output dpb_pkg::cfg_t                       cfg
);
  import dpb_pkg::*;

  cfg_t                 cfg_r;
  cfg_t                 cfg_nxt;
  logic [CFG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_DEPTH_COEF:   cfg_nxt.depth_coefficient  = pwdata[COEF_W-1:0];
        REG_DEPTH_LIMIT:  cfg_nxt.depth_limit        = pwdata[LIMIT_W-1:0];
        REG_FOCAL_X_RCP:  cfg_nxt.focal_x_reciprocal = pwdata[RECIP_W-1:0];
        REG_FOCAL_Y_RCP:  cfg_nxt.focal_y_reciprocal = pwdata[RECIP_W-1:0];
        REG_CENTER_X:     cfg_nxt.center_x           = pwdata[CENTER_W-1:0];
        REG_CENTER_Y:     cfg_nxt.center_y           = pwdata[CENTER_W-1:0];
        REG_STRIDE_SHIFT: cfg_nxt.stride_shift       = pwdata[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{depth_coefficient:  '0,
                 depth_limit:        DEPTH_LIMIT_RESET,
                 focal_x_reciprocal: '0,
                 focal_y_reciprocal: '0,
                 center_x:           '0,
                 center_y:           '0,
                 stride_shift:       '0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_DEPTH_COEF:   prdata = CFG_DATA_W'(cfg_r.depth_coefficient);
      REG_DEPTH_LIMIT:  prdata = CFG_DATA_W'(cfg_r.depth_limit);
      REG_FOCAL_X_RCP:  prdata = CFG_DATA_W'(cfg_r.focal_x_reciprocal);
      REG_FOCAL_Y_RCP:  prdata = CFG_DATA_W'(cfg_r.focal_y_reciprocal);
      REG_CENTER_X:     prdata = CFG_DATA_W'(cfg_r.center_x);
      REG_CENTER_Y:     prdata = CFG_DATA_W'(cfg_r.center_y);
      REG_STRIDE_SHIFT: prdata = CFG_DATA_W'(cfg_r.stride_shift);
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/dpb_div.sv
// Pipelined restoring divider, 32-bit dividend by 16-bit divisor, with a
// side payload that travels beside the quotient. Depends on dpb_pkg.
`default_nettype none

module dpb_div #(
  parameter int PAY_W = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          ce,
  input  wire logic                          in_valid,
  input  wire logic [dpb_pkg::COEF_W-1:0]    in_dividend,
  input  wire logic [dpb_pkg::DISP_W-1:0]    in_divisor,
  input  wire logic [PAY_W-1:0]              in_pay,
  output logic                               out_valid,
  output logic      [dpb_pkg::COEF_W-1:0]    out_quot,
  output logic      [PAY_W-1:0]              out_pay
);
  import dpb_pkg::*;

  localparam int NS = COEF_W / DIV_BITS_PER_STAGE;

  logic              vld_r [0:NS-1];
  logic [DISP_W-1:0] rem_r [0:NS-1];
  logic [COEF_W-1:0] quo_r [0:NS-1];
  logic [DISP_W-1:0] dsr_r [0:NS-1];
  logic [PAY_W-1:0]  pay_r [0:NS-1];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic              cur_vld;
    logic [DISP_W-1:0] cur_rem;
    logic [COEF_W-1:0] cur_quo;
    logic [DISP_W-1:0] cur_dsr;
    logic [PAY_W-1:0]  cur_pay;
    logic [DISP_W-1:0] rem_nxt;
    logic [COEF_W-1:0] quo_nxt;
    logic [DISP_W:0]   trial;

    if (s == 0) begin : g_head
      assign cur_vld = in_valid;
      assign cur_rem = '0;
      assign cur_quo = in_dividend;
      assign cur_dsr = in_divisor;
      assign cur_pay = in_pay;
    end else begin : g_body
      assign cur_vld = vld_r[s-1];
      assign cur_rem = rem_r[s-1];
      assign cur_quo = quo_r[s-1];
      assign cur_dsr = dsr_r[s-1];
      assign cur_pay = pay_r[s-1];
    end

    always_comb begin
      rem_nxt = cur_rem;
      quo_nxt = cur_quo;
      trial   = '0;
      for (int k = 0; k < DIV_BITS_PER_STAGE; k++) begin
        trial   = {rem_nxt, quo_nxt[COEF_W-1]};
        quo_nxt = {quo_nxt[COEF_W-2:0], 1'b0};
        if (trial >= {1'b0, cur_dsr}) begin
          trial      = trial - {1'b0, cur_dsr};
          quo_nxt[0] = 1'b1;
        end
        rem_nxt = trial[DISP_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (ce) begin
        vld_r[s] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[s] <= rem_nxt;
        quo_r[s] <= quo_nxt;
        dsr_r[s] <= cur_dsr;
        pay_r[s] <= cur_pay;
      end
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_quot  = quo_r[NS-1];
  assign out_pay   = pay_r[NS-1];

endmodule

`default_nettype wire

// File: rtl/dpb_proj.sv
// One axis of the back-projection: |offset| * z * reciprocal focal, rounded,
// signed and saturated over three register stages. Depends on dpb_pkg.
`default_nettype none

module dpb_proj #(
  parameter int MAG_W = 16
) (
  input  wire logic                            clk,
  input  wire logic                            ce,
  input  wire logic [MAG_W-1:0]                mag,
  input  wire logic                            neg,
  input  wire logic [dpb_pkg::Z_W-1:0]         z,
  input  wire logic [dpb_pkg::RECIP_W-1:0]     recip,
  output logic      [dpb_pkg::POINT_W-1:0]     point
);
  import dpb_pkg::*;

  localparam int PW = MAG_W + Z_W;
  localparam int H  = PW / 2;
  localparam int SW = PW + RECIP_W;
  localparam int QW = SW - SCALE_BITS;

  localparam logic [SW-1:0] ROUND = {{(SW - SCALE_BITS){1'b0}}, 1'b1,
                                     {(SCALE_BITS - 1){1'b0}}};

  logic [PW-1:0]             mz_r;
  logic                      neg1_r;
  logic [H+RECIP_W-1:0]      plo_r;
  logic [PW-H+RECIP_W-1:0]   phi_r;
  logic                      neg2_r;
  logic [SW-1:0]             sum;
  logic [QW-1:0]             q;
  logic                      big;
  logic [POINT_W-1:0]        point_nxt;
  logic [POINT_W-1:0]        point_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      mz_r   <= PW'(mag) * PW'(z);
      neg1_r <= neg;
      plo_r  <= (H+RECIP_W)'(mz_r[H-1:0]) * (H+RECIP_W)'(recip);
      phi_r  <= (PW-H+RECIP_W)'(mz_r[PW-1:H]) * (PW-H+RECIP_W)'(recip);
      neg2_r <= neg1_r;
      point_r <= point_nxt;
    end
  end

  assign sum = {phi_r, {H{1'b0}}} + SW'(plo_r) + ROUND;
  assign q   = sum[SW-1:SCALE_BITS];
  assign big = |q[QW-1:POINT_W-1];

  always_comb begin
    if (neg2_r) begin
      point_nxt = big ? {1'b1, {(POINT_W-1){1'b0}}} : (~q[POINT_W-1:0] + 1'b1);
    end else begin
      point_nxt = big ? {1'b0, {(POINT_W-1){1'b1}}} : q[POINT_W-1:0];
    end
  end

  assign point = point_r;

endmodule

`default_nettype wire

// File: rtl/disparity_to_point_backprojection.sv
// Disparity-to-point back-projection: one pixel word in per clock when the
// output is not stalled, one point word out for each kept pixel. From
// input to output register, 8 divider stages (4 quotient bits each)
// produce depth, then 3 stages multiply, round and saturate x and y.
// Sustained rate is one pixel per clock; a stall on the output holds the
// whole pipeline. Depends on dpb_pkg, dpb_cfg, dpb_div and dpb_proj.
`default_nettype none

module disparity_to_point_backprojection #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // pixel_column, pixel_row, disparity_raw
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [((2*COORD_BITS+16+7)/8)*8-1:0] in_tdata,
  // point_x, point_y, point_z, out_column, out_row
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [((2*COORD_BITS+84+7)/8)*8-1:0] out_tdata,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [dpb_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [dpb_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic      [dpb_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                                 cfg_pready
);
  import dpb_pkg::*;

  localparam int C      = COORD_BITS;
  localparam int OUT_W  = ((2*C+84+7)/8)*8;
  localparam int POS_W  = C + CENTER_FRAC_BITS;
  localparam int MAG_W  = (POS_W > CENTER_W) ? POS_W : CENTER_W;
  localparam int PAY_W  = 1 + 2*(1 + MAG_W) + 2*C;
  localparam int TAIL   = 3;

  cfg_t cfg;

  dpb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  logic ce;
  assign ce        = !out_tvalid || out_tready;
  assign in_tready = ce;

  logic [C-1:0]      in_u;
  logic [C-1:0]      in_v;
  logic [DISP_W-1:0] in_d;
  logic [C-1:0]      gmask;
  logic              in_keep;
  logic [MAG_W-1:0]  pos_x;
  logic [MAG_W-1:0]  pos_y;
  logic [MAG_W-1:0]  cen_x;
  logic [MAG_W-1:0]  cen_y;
  logic              in_negx;
  logic              in_negy;
  logic [MAG_W-1:0]  in_magx;
  logic [MAG_W-1:0]  in_magy;

  assign in_u  = in_tdata[C-1:0];
  assign in_v  = in_tdata[2*C-1:C];
  assign in_d  = in_tdata[2*C+DISP_W-1:2*C];
  assign gmask = ~({C{1'b1}} << cfg.stride_shift);
  assign in_keep = ((in_u & gmask) == '0) && ((in_v & gmask) == '0) && (in_d != '0);

  assign pos_x   = MAG_W'({in_u, {CENTER_FRAC_BITS{1'b0}}});
  assign pos_y   = MAG_W'({in_v, {CENTER_FRAC_BITS{1'b0}}});
  assign cen_x   = MAG_W'(cfg.center_x);
  assign cen_y   = MAG_W'(cfg.center_y);
  assign in_negx = pos_x < cen_x;
  assign in_negy = pos_y < cen_y;
  assign in_magx = in_negx ? (cen_x - pos_x) : (pos_x - cen_x);
  assign in_magy = in_negy ? (cen_y - pos_y) : (pos_y - cen_y);

  logic              div_vld;
  logic [COEF_W-1:0] div_quot;
  logic [PAY_W-1:0]  div_pay;

  dpb_div #(.PAY_W(PAY_W)) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .ce          (ce),
    .in_valid    (in_tvalid),
    .in_dividend (cfg.depth_coefficient),
    .in_divisor  (in_d),
    .in_pay      ({in_keep, in_negx, in_magx, in_negy, in_magy, in_u, in_v}),
    .out_valid   (div_vld),
    .out_quot    (div_quot),
    .out_pay     (div_pay)
  );

  logic             d_keep;
  logic             d_negx;
  logic             d_negy;
  logic [MAG_W-1:0] d_magx;
  logic [MAG_W-1:0] d_magy;
  logic [C-1:0]     d_u;
  logic [C-1:0]     d_v;
  logic [Z_W-1:0]   d_z;
  logic             d_ok;

  assign {d_keep, d_negx, d_magx, d_negy, d_magy, d_u, d_v} = div_pay;
  assign d_z  = div_quot[Z_W-1:0];
  assign d_ok = d_keep && (div_quot != '0) && (div_quot <= COEF_W'(cfg.depth_limit));

  logic [POINT_W-1:0] px;
  logic [POINT_W-1:0] py;

  dpb_proj #(.MAG_W(MAG_W)) u_proj_x (
    .clk   (clk),
    .ce    (ce),
    .mag   (d_magx),
    .neg   (d_negx),
    .z     (d_z),
    .recip (cfg.focal_x_reciprocal),
    .point (px)
  );

  dpb_proj #(.MAG_W(MAG_W)) u_proj_y (
    .clk   (clk),
    .ce    (ce),
    .mag   (d_magy),
    .neg   (d_negy),
    .z     (d_z),
    .recip (cfg.focal_y_reciprocal),
    .point (py)
  );

  logic           tv_r [0:TAIL-1];
  logic [Z_W-1:0] tz_r [0:TAIL-1];
  logic [C-1:0]   tu_r [0:TAIL-1];
  logic [C-1:0]   tw_r [0:TAIL-1];

  for (genvar s = 0; s < TAIL; s++) begin : g_tail
    logic           src_v;
    logic [Z_W-1:0] src_z;
    logic [C-1:0]   src_u;
    logic [C-1:0]   src_w;

    if (s == 0) begin : g_head
      assign src_v = div_vld && d_ok;
      assign src_z = d_z;
      assign src_u = d_u;
      assign src_w = d_v;
    end else begin : g_body
      assign src_v = tv_r[s-1];
      assign src_z = tz_r[s-1];
      assign src_u = tu_r[s-1];
      assign src_w = tw_r[s-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tv_r[s] <= 1'b0;
      end else if (ce) begin
        tv_r[s] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        tz_r[s] <= src_z;
        tu_r[s] <= src_u;
        tw_r[s] <= src_w;
      end
    end
  end

  assign out_tvalid = tv_r[TAIL-1];
  assign out_tdata  = OUT_W'({tw_r[TAIL-1], tu_r[TAIL-1], tz_r[TAIL-1], py, px});

endmodule

`default_nettype wire

// File: tb/disparity_to_point_backprojection_tb.sv
// Testbench for disparity_to_point_backprojection: directed and random pixel
// words, predicted points checked field by field under random stalls.
// Depends on dpb_pkg and the block's RTL.
`timescale 1ns / 1ps

module disparity_to_point_backprojection_tb;
  import dpb_pkg::*;

  localparam int COORD_BITS    = 12;
  localparam int IN_W          = ((2*COORD_BITS+16+7)/8)*8;
  localparam int OUT_W         = ((2*COORD_BITS+84+7)/8)*8;
  localparam int PIPE_LATENCY  = 11;
  localparam int SETTLE_CYCLES = 4*PIPE_LATENCY + 20;
  localparam int LONG_HOLD     = 300;
  localparam int CYCLE_LIMIT   = 400000;
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_REG = 3'd7;

  typedef struct packed {
    logic [POINT_W-1:0]    x;
    logic [POINT_W-1:0]    y;
    logic [Z_W-1:0]        z;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
  } point_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // pixel_column, pixel_row, disparity_raw
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // point_x, point_y, point_z, out_column, out_row
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  cfg_t   cfg_mirror;
  point_t pending_points[$];
  point_t oldest_point;
  int     mismatch_count = 0;
  int     cycle_count = 0;
  bit     tx_idle_en = 1'b1;
  bit     rx_idle_en = 1'b1;
  bit     rx_hold_req = 1'b0;

  disparity_to_point_backprojection #(.COORD_BITS(COORD_BITS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL disparity_to_point_backprojection");
      $finish;
    end
  end

  function automatic logic [POINT_W-1:0] axis_offset(input logic [COORD_BITS-1:0] coord,
                                                     input logic [CENTER_W-1:0] center,
                                                     input logic [Z_W-1:0] depth,
                                                     input logic [RECIP_W-1:0] recip);
    logic [63:0] pos;
    logic [63:0] cen;
    logic [63:0] mag;
    logic [63:0] scaled;
    logic        below;
    pos    = 64'(coord) << CENTER_FRAC_BITS;
    cen    = 64'(center);
    below  = pos < cen;
    mag    = below ? cen - pos : pos - cen;
    scaled = (mag * 64'(depth) * 64'(recip) + (64'd1 << (SCALE_BITS-1))) >> SCALE_BITS;
    if (below)
      return (scaled >= 64'h8000_0000) ? 32'h8000_0000 : -scaled[31:0];
    return (scaled > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : scaled[31:0];
  endfunction

  function automatic bit backproject(input logic [COORD_BITS-1:0] u,
                                     input logic [COORD_BITS-1:0] v,
                                     input logic [DISP_W-1:0] d, output point_t pt);
    logic [COEF_W-1:0]     depth;
    logic [COORD_BITS-1:0] grid;
    pt   = '0;
    grid = COORD_BITS'((16'd1 << cfg_mirror.stride_shift) - 16'd1);
    if (((u | v) & grid) != 0 || d == 0)
      return 1'b0;
    depth = cfg_mirror.depth_coefficient / COEF_W'(d);
    if (depth == 0 || depth > COEF_W'(cfg_mirror.depth_limit))
      return 1'b0;
    pt.x   = axis_offset(u, cfg_mirror.center_x, depth[Z_W-1:0], cfg_mirror.focal_x_reciprocal);
    pt.y   = axis_offset(v, cfg_mirror.center_y, depth[Z_W-1:0], cfg_mirror.focal_y_reciprocal);
    pt.z   = depth[Z_W-1:0];
    pt.col = u;
    pt.row = v;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [POINT_W-1:0] want,
                             input logic [POINT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected point word, expected none actual %h", $time, out_tdata);
        mismatch_count++;
      end else begin
        oldest_point = pending_points.pop_front();
        check_field("point_x", oldest_point.x, out_tdata[31:0]);
        check_field("point_y", oldest_point.y, out_tdata[63:32]);
        check_field("point_z", POINT_W'(oldest_point.z), POINT_W'(out_tdata[83:64]));
        check_field("out_column", POINT_W'(oldest_point.col), POINT_W'(out_tdata[95:84]));
        check_field("out_row", POINT_W'(oldest_point.row), POINT_W'(out_tdata[107:96]));
      end
    end
  end

  initial begin : point_sink
    int gap;
    @(posedge rst_n);
    forever begin
      if (rx_hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        rx_hold_req = 1'b0;
      end
      gap = rx_idle_en ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready) && !rx_hold_req);
    end
  end

  task automatic send_pixel(input logic [COORD_BITS-1:0] u, input logic [COORD_BITS-1:0] v,
                            input logic [DISP_W-1:0] d);
    int     gap;
    point_t pt;
    gap = tx_idle_en ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {d, v, u};
    do @(posedge clk); while (!in_tready);
    if (backproject(u, v, d, pt))
      pending_points = {pending_points, pt};
  endtask

  task automatic settle_pipeline();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_points.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_DEPTH_COEF:   cfg_mirror.depth_coefficient  = value;
      REG_DEPTH_LIMIT:  cfg_mirror.depth_limit        = value[LIMIT_W-1:0];
      REG_FOCAL_X_RCP:  cfg_mirror.focal_x_reciprocal = value[RECIP_W-1:0];
      REG_FOCAL_Y_RCP:  cfg_mirror.focal_y_reciprocal = value[RECIP_W-1:0];
      REG_CENTER_X:     cfg_mirror.center_x           = value[CENTER_W-1:0];
      REG_CENTER_Y:     cfg_mirror.center_y           = value[CENTER_W-1:0];
      REG_STRIDE_SHIFT: cfg_mirror.stride_shift       = value[STRIDE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_camera(input logic [31:0] coef, input logic [31:0] limit,
                             input logic [31:0] fx, input logic [31:0] fy,
                             input logic [31:0] cx, input logic [31:0] cy,
                             input logic [31:0] stride);
    write_reg(REG_DEPTH_COEF, coef);
    write_reg(REG_DEPTH_LIMIT, limit);
    write_reg(REG_FOCAL_X_RCP, fx);
    write_reg(REG_FOCAL_Y_RCP, fy);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_STRIDE_SHIFT, stride);
  endtask

  task automatic test_reset_config();
    send_pixel(12'd0, 12'd0, 16'd1);
    send_pixel(12'd4095, 12'd4095, 16'hFFFF);
    send_pixel(12'd100, 12'd200, 16'd0);
    settle_pipeline();
  endtask

  task automatic test_saturation();
    load_camera(32'hFFFF_FFFF, 32'hF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF, 32'h0, 32'hFFFF, 32'd0);
    send_pixel(12'd4095, 12'd0, 16'd4096);
    send_pixel(12'd0, 12'd4095, 16'hFFFF);
    send_pixel(12'd0, 12'd0, 16'd0);
    send_pixel(12'd4095, 12'd4095, 16'd1);
    send_pixel(12'd1, 12'd2, 16'd4097);
    send_pixel(12'd2048, 12'd2048, 16'hFFFF);
    settle_pipeline();
  endtask

  task automatic test_limit_and_grid();
    load_camera(32'd1000, 32'd100, 32'h0, 32'h10_0000, 32'h8000, 32'h7FF8, 32'd2);
    send_pixel(12'd4, 12'd8, 16'd10);
    send_pixel(12'd4, 12'd8, 16'd9);
    send_pixel(12'd4, 12'd8, 16'd2000);
    send_pixel(12'd5, 12'd8, 16'd10);
    send_pixel(12'd4, 12'd9, 16'd10);
    send_pixel(12'd2044, 12'd4092, 16'd11);
    settle_pipeline();
  endtask

  task automatic test_wide_stride();
    load_camera(32'h0010_0000, 32'hF_FFFF, 32'h01_2345, 32'hFE_DCBA, 32'h1234, 32'hFFFF, 32'd5);
    send_pixel(12'd32, 12'd64, 16'd300);
    send_pixel(12'd16, 12'd0, 16'd300);
    settle_pipeline();
    write_reg(REG_STRIDE_SHIFT, 32'd6);
    send_pixel(12'd64, 12'd4032, 16'd7);
    send_pixel(12'd32, 12'd64, 16'd7);
    settle_pipeline();
    write_reg(REG_STRIDE_SHIFT, 32'd7);
    send_pixel(12'd128, 12'd3968, 16'd1000);
    send_pixel(12'd64, 12'd128, 16'd1000);
    settle_pipeline();
    write_reg(UNMAPPED_REG, 32'hFFFF_FFFF);
    send_pixel(12'd0, 12'd0, 16'd2);
    settle_pipeline();
    write_reg(REG_DEPTH_LIMIT, 32'd0);
    send_pixel(12'd0, 12'd0, 16'd1);
    settle_pipeline();
  endtask

  task automatic test_output_backpressure();
    load_camera(32'h0800_0000, 32'hF_FFFF, $urandom, $urandom, $urandom, $urandom, 32'd0);
    tx_idle_en  = 1'b0;
    rx_hold_req = 1'b1;
    repeat (60)
      send_pixel(12'($urandom), 12'($urandom), 16'($urandom_range(200, 65535)));
    settle_pipeline();
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random_phases();
    logic [31:0]           coef;
    logic [31:0]           limit;
    logic [31:0]           recip [2];
    logic [31:0]           center [2];
    logic [31:0]           stride;
    logic [COORD_BITS-1:0] grid;
    logic [COORD_BITS-1:0] u;
    logic [COORD_BITS-1:0] v;
    logic [DISP_W-1:0]     d;
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 3))
        0: coef = $urandom;
        1: coef = 32'hFFFF_FFFF;
        2: coef = $urandom & 32'h00FF_FFFF;
        default: coef = $urandom >> $urandom_range(0, 31);
      endcase
      case ($urandom_range(0, 3))
        0, 1: limit = 32'hF_FFFF;
        2: limit = $urandom & 32'hF_FFFF;
        default: limit = $urandom_range(0, 1023);
      endcase
      for (int k = 0; k < 2; k++) begin
        case ($urandom_range(0, 4))
          0: recip[k] = 32'h0;
          1: recip[k] = 32'hFF_FFFF;
          default: recip[k] = $urandom & 32'hFF_FFFF;
        endcase
        case ($urandom_range(0, 4))
          0: center[k] = 32'h0;
          1: center[k] = 32'hFFFF;
          default: center[k] = $urandom & 32'hFFFF;
        endcase
      end
      stride = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 2);
      load_camera(coef, limit, recip[0], recip[1], center[0], center[1], stride);
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      grid = COORD_BITS'((16'd1 << stride[STRIDE_W-1:0]) - 16'd1);
      repeat (95) begin
        u = COORD_BITS'($urandom);
        v = COORD_BITS'($urandom);
        if ($urandom_range(0, 4) != 0) begin
          u = u & ~grid;
          v = v & ~grid;
        end
        case ($urandom_range(0, 19))
          0: d = '0;
          1: d = DISP_W'($urandom_range(1, 15));
          2: d = 16'hFFFF;
          default: d = DISP_W'($urandom_range(1, 65535));
        endcase
        send_pixel(u, v, d);
      end
      settle_pipeline();
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    cfg_mirror = '0;
    cfg_mirror.depth_limit = DEPTH_LIMIT_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_config();
    test_saturation();
    test_limit_and_grid();
    test_wide_stride();
    test_output_backpressure();
    test_random_phases();
    settle_pipeline();
    if (mismatch_count == 0)
      $display("PASS disparity_to_point_backprojection");
    else
      $display("FAIL disparity_to_point_backprojection");
    $finish;
  end

endmodule

// File: disparity_to_point_backprojection.f
rtl/dpb_pkg.sv
rtl/dpb_cfg.sv
rtl/dpb_div.sv
rtl/dpb_proj.sv
rtl/disparity_to_point_backprojection.sv
tb/disparity_to_point_backprojection_tb.sv
